### sv/scsa_pkg.sv
package scsa_pkg;

  // Size classes
  localparam int unsigned NUM_CLASSES   = 12;
  localparam int unsigned ClassW        = 4;
  localparam int unsigned SizeW         = 20;
  localparam int unsigned ClassSizeW    = 16;
  localparam logic [SizeW-1:0] BIGGEST_CLASS = 20'd32768;

  // Result field widths
  localparam int unsigned StatusW   = 3;
  localparam int unsigned SlabOutW  = 2;
  localparam int unsigned SlotOutW  = 6;
  localparam int unsigned RawSlotsW = 7;

  // Request kinds (travel on tuser)
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_ALLOCATED  = 3'd0,
    ST_FREED      = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_NOT_IN_USE = 3'd4
  } status_e;

  // Slot size in bytes per class
  function automatic logic [ClassSizeW:0] class_bytes(input logic [ClassW-1:0] c);
    logic [ClassSizeW:0] b;
    case (c)
      4'd0:    b = 17'd4;
      4'd1:    b = 17'd16;
      4'd2:    b = 17'd32;
      4'd3:    b = 17'd64;
      4'd4:    b = 17'd128;
      4'd5:    b = 17'd512;
      4'd6:    b = 17'd1024;
      4'd7:    b = 17'd2048;
      4'd8:    b = 17'd4096;
      4'd9:    b = 17'd8192;
      4'd10:   b = 17'd16384;
      default: b = 17'd32768;
    endcase
    return b;
  endfunction

  // Slots per slab, (span - 12) / (size + 4) capped at 64.
  // Span is 0x10000 for classes 0..6 and 0x100000 for the rest.
  function automatic logic [RawSlotsW-1:0] class_slots(input logic [ClassW-1:0] c);
    logic [RawSlotsW-1:0] n;
    case (c)
      4'd6:    n = 7'd63;
      4'd10:   n = 7'd63;
      4'd11:   n = 7'd31;
      default: n = 7'd64;
    endcase
    return n;
  endfunction

  // First class whose slot size holds the request (size <= 32768)
  function automatic logic [ClassW-1:0] class_of_size(input logic [SizeW-1:0] size);
    logic [ClassW-1:0] c;
    logic              hit;
    c   = ClassW'(NUM_CLASSES - 1);
    hit = 1'b0;
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (!hit && ({3'b000, class_bytes(ClassW'(i))} >= size)) begin
        c   = ClassW'(i);
        hit = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

### sv/size_class_slab_allocator_core.sv
// Channel   | Dir | Handshake                   | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser: kind; tdata: request_size, free_class,
//           |     |                             |   free_slab, free_slot
// m_axis    | out | m_axis_tvalid/m_axis_tready | tuser: status; tdata: class, slab, slot
//
// One request at a time. The slab state sits in one memory (busy map plus used count per
// slab) with a registered read; each slab tried costs one memory read and one evaluation.
// Allocate: the recent slab if the class has one open, then a walk over all slabs.
// Free: one slab read, then the evaluation. Too-large or out-of-range free: answered from idle.
// Reset clears the per-slab valid bits and the per-class counters at once; no clearing pass.
// The result waits in an output register; a stalled m_axis holds off new requests.
module size_class_slab_allocator_core
  import scsa_pkg::*;
#(
  parameter int unsigned SLABS_PER_CLASS = 4,
  parameter int unsigned SLOTS_MAX       = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [19:0] request_size, [23:20] free_class, [25:24] free_slab, [31:26] free_slot
  input  logic [31:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] class_index, [5:4] slab_index, [11:6] slot_index, [15:12] zero
  output logic [15:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned NumSlabs = NUM_CLASSES * SLABS_PER_CLASS;
  localparam int unsigned AddrW    = $clog2(NumSlabs);
  localparam int unsigned SlabW    = (SLABS_PER_CLASS > 1) ? $clog2(SLABS_PER_CLASS) : 1;
  localparam int unsigned OpenW    = $clog2(SLABS_PER_CLASS + 1);
  localparam int unsigned SlotW    = $clog2(SLOTS_MAX);
  localparam int unsigned CntW     = $clog2(SLOTS_MAX + 1);
  localparam int unsigned WordW    = SLOTS_MAX + CntW;

  // State codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;

  // Input fields
  logic [SizeW-1:0]    req_size;
  logic [ClassW-1:0]   req_class;
  logic [SlabOutW-1:0] req_slab;
  logic [SlotOutW-1:0] req_slot;
  assign req_size  = s_axis_tdata[19:0];
  assign req_class = s_axis_tdata[23:20];
  assign req_slab  = s_axis_tdata[25:24];
  assign req_slot  = s_axis_tdata[31:26];

  // Control registers
  logic [1:0]        state_q, state_d;
  logic [ClassW-1:0] cls_q, cls_d;
  logic [SlabW-1:0]  slab_q, slab_d;
  logic              walk_q, walk_d;
  logic [SlotW-1:0]  fslot_q, fslot_d;
  logic [AddrW-1:0]  addr_q;

  // Per-class counters
  logic [OpenW-1:0] opened_q [NUM_CLASSES];
  logic [SlabW-1:0] recent_q [NUM_CLASSES];
  logic             open_we;

  // Output register
  logic                m_valid_q;
  logic [StatusW-1:0]  ost_q, ost_d;
  logic [ClassW-1:0]   ocls_q, ocls_d;
  logic [SlabOutW-1:0] oslab_q, oslab_d;
  logic [SlotOutW-1:0] oslot_q, oslot_d;
  logic                out_load;

  // Slab memory: {used count, busy map}
  logic [WordW-1:0] mem [NumSlabs];
  logic [WordW-1:0] rdata_q;
  logic             rvalid_q;
  logic             ent_valid_q [NumSlabs];
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;
  logic [WordW-1:0] wdata;

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Current slab word, zero when never written
  logic [SLOTS_MAX-1:0] busy;
  logic [CntW-1:0]      used;
  assign busy = rvalid_q ? rdata_q[SLOTS_MAX-1:0] : '0;
  assign used = rvalid_q ? rdata_q[WordW-1:SLOTS_MAX] : '0;

  // Slot count of the current class
  logic [CntW-1:0] n_cur;
  always_comb begin
    if (int'(class_slots(cls_q)) > SLOTS_MAX) begin
      n_cur = CntW'(SLOTS_MAX);
    end else begin
      n_cur = CntW'(class_slots(cls_q));
    end
  end

  // Free slot search: from the used count upward, then from slot 0
  logic [SLOTS_MAX-1:0] free_vec, hi_vec;
  logic [SlotW-1:0]     hi_idx, lo_idx, pick;
  logic                 hi_any, lo_any, found;
  always_comb begin
    for (int i = 0; i < SLOTS_MAX; i++) begin
      free_vec[i] = !busy[i] && (CntW'(i) < n_cur);
      hi_vec[i]   = free_vec[i] && (CntW'(i) >= used);
    end
    hi_idx = '0;
    lo_idx = '0;
    for (int i = SLOTS_MAX - 1; i >= 0; i--) begin
      if (hi_vec[i]) hi_idx = SlotW'(i);
      if (free_vec[i]) lo_idx = SlotW'(i);
    end
    hi_any = |hi_vec;
    lo_any = |free_vec;
    pick   = hi_any ? hi_idx : lo_idx;
    found  = (used < n_cur) && lo_any;
  end

  // Slab address helper
  function automatic logic [AddrW-1:0] slab_addr(input logic [ClassW-1:0] c,
                                                 input logic [SlabW-1:0] s);
    return AddrW'(AddrW'(c) * AddrW'(SLABS_PER_CLASS)) + AddrW'(s);
  endfunction

  logic [ClassW-1:0] alloc_cls;
  logic              in_range;
  logic              fbit;
  assign alloc_cls = class_of_size(req_size);
  assign in_range  = (int'(req_class) < NUM_CLASSES) && (int'(req_slab) < SLABS_PER_CLASS) &&
                     (int'(req_slot) < SLOTS_MAX);
  assign fbit      = busy[fslot_q];

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cls_d    = cls_q;
    slab_d   = slab_q;
    walk_d   = walk_q;
    fslot_d  = fslot_q;
    rd_addr  = addr_q;
    mem_we   = 1'b0;
    wdata    = rdata_q;
    open_we  = 1'b0;
    out_load = 1'b0;
    ost_d    = ost_q;
    ocls_d   = ocls_q;
    oslab_d  = oslab_q;
    oslot_d  = oslot_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == KIND_FREE) begin
            cls_d   = req_class;
            slab_d  = SlabW'(req_slab);
            fslot_d = SlotW'(req_slot);
            ocls_d  = req_class;
            oslab_d = req_slab;
            oslot_d = req_slot;
            if (in_range) begin
              rd_addr = slab_addr(req_class, SlabW'(req_slab));
              state_d = S_FREE;
            end else begin
              ost_d    = ST_NOT_IN_USE;
              out_load = 1'b1;
            end
          end else if (req_size > BIGGEST_CLASS) begin
            ost_d    = ST_TOO_LARGE;
            ocls_d   = '0;
            oslab_d  = '0;
            oslot_d  = '0;
            out_load = 1'b1;
          end else begin
            cls_d = alloc_cls;
            if (opened_q[alloc_cls] != '0) begin
              slab_d = recent_q[alloc_cls];
              walk_d = 1'b0;
            end else begin
              slab_d = '0;
              walk_d = 1'b1;
            end
            rd_addr = slab_addr(alloc_cls, slab_d);
            state_d = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        // the walk opens each slab it reaches
        if (walk_q && (OpenW'(slab_q) >= opened_q[cls_q])) begin
          open_we = 1'b1;
        end
        ocls_d = cls_q;
        if (found) begin
          mem_we   = 1'b1;
          wdata    = {used + CntW'(1), busy | (SLOTS_MAX'(1) << pick)};
          ost_d    = ST_ALLOCATED;
          oslab_d  = SlabOutW'(slab_q);
          oslot_d  = SlotOutW'(pick);
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else if (!walk_q) begin
          walk_d  = 1'b1;
          slab_d  = '0;
          rd_addr = slab_addr(cls_q, '0);
        end else if (slab_q == SlabW'(SLABS_PER_CLASS - 1)) begin
          ost_d    = ST_NO_SPACE;
          oslab_d  = '0;
          oslot_d  = '0;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          slab_d  = slab_q + SlabW'(1);
          rd_addr = slab_addr(cls_q, slab_d);
        end
      end
      S_FREE: begin
        // echo the request fields held since acceptance
        ocls_d  = cls_q;
        oslab_d = SlabOutW'(slab_q);
        oslot_d = SlotOutW'(fslot_q);
        if (fbit) begin
          mem_we = 1'b1;
          wdata  = {(used != '0) ? used - CntW'(1) : used,
                    busy & ~(SLOTS_MAX'(1) << fslot_q)};
          ost_d  = ST_FREED;
        end else begin
          ost_d  = ST_NOT_IN_USE;
        end
        out_load = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        opened_q[i] <= '0;
        recent_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      if (open_we) begin
        opened_q[cls_q] <= OpenW'(slab_q) + OpenW'(1);
        recent_q[cls_q] <= slab_q;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    cls_q   <= cls_d;
    slab_q  <= slab_d;
    fslot_q <= fslot_d;
    addr_q  <= rd_addr;
  end

  // Slab memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  // Entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      for (int i = 0; i < NumSlabs; i++) begin
        ent_valid_q[i] <= 1'b0;
      end
    end else begin
      rvalid_q <= ent_valid_q[rd_addr];
      if (mem_we) begin
        ent_valid_q[addr_q] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ost_q   <= ost_d;
      ocls_q  <= ocls_d;
      oslab_q <= oslab_d;
      oslot_q <= oslot_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {4'b0000, oslot_q, oslab_q, ocls_q};

  // Checks
  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !m_valid_q)
    else $error("result register occupied while a request is in flight");

  a_write_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_ALLOC || state_q == S_FREE))
    else $error("slab memory written outside evaluation");

  a_alloc_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (int'(cls_q) < NUM_CLASSES))
    else $error("allocate walk on a class out of range");

  a_load_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && state_q != S_IDLE) |=> (state_q == S_IDLE && m_valid_q))
    else $error("result not presented after evaluation");

endmodule

### sim/tb_top.sv
module tb_top
  import scsa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLABS      = 4;
  localparam int unsigned MAX_SLOTS  = 64;
  localparam int unsigned NUM_SLABS  = NUM_CLASSES * SLABS;
  localparam int unsigned RAND_ITEMS = 800;
  localparam int unsigned CYCLE_CAP  = 300000;

  // slot size per class, in bytes
  localparam int unsigned SLOT_BYTES [12] = '{
    4, 16, 32, 64, 128, 512, 1024, 2048, 4096, 8192, 16384, 32768
  };

  typedef struct packed {
    status_e     status;
    logic [3:0]  cls;
    logic [1:0]  slab;
    logic [5:0]  slot;
  } reply_t;

  // Allocator state mirror plus the queue of replies still owed by the block
  class slab_book;
    bit [63:0]   busy_map [NUM_SLABS];
    int unsigned used_cnt [NUM_SLABS];
    int unsigned opened   [NUM_CLASSES];
    int unsigned recent   [NUM_CLASSES];
    reply_t      pending_replies [$];
    logic [11:0] live_slots [$];   // {class, slab, slot} of each busy slot
    int unsigned errors;

    function automatic int unsigned slots_per_slab(int unsigned c);
      int unsigned span;
      int unsigned n;
      span = (c < 7) ? 32'h10000 : 32'h100000;
      span = ((span + 4095) / 4096) * 4096;
      n    = (span - 12) / (SLOT_BYTES[c] + 4);
      return (n > MAX_SLOTS) ? MAX_SLOTS : n;
    endfunction

    // search from the used count upward, then wrap to slot 0
    function automatic bit claim_slot(int unsigned c, int unsigned s, output int unsigned got);
      int unsigned idx;
      int unsigned n;
      int unsigned used;
      idx  = c * SLABS + s;
      n    = slots_per_slab(c);
      used = used_cnt[idx];
      got  = 0;
      if (used >= n) return 1'b0;
      for (int unsigned i = used; i < n; i++) begin
        if (!busy_map[idx][i]) begin
          got = i;
          busy_map[idx][i] = 1'b1;
          used_cnt[idx] = used + 1;
          return 1'b1;
        end
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (!busy_map[idx][i]) begin
          got = i;
          busy_map[idx][i] = 1'b1;
          used_cnt[idx] = used + 1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Predict the reply for one accepted request and update the mirror
    function automatic void note_request(logic kind, logic [19:0] size, logic [3:0] fc,
                                         logic [1:0] fs, logic [5:0] fslot);
      reply_t      r;
      int unsigned c;
      int unsigned got;
      int unsigned idx;
      bit          ok;
      r.status = ST_ALLOCATED;
      r.cls    = '0;
      r.slab   = '0;
      r.slot   = '0;
      if (kind == KIND_ALLOC) begin
        if (size > 32768) begin
          r.status = ST_TOO_LARGE;
        end else begin
          c = NUM_CLASSES - 1;
          for (int i = NUM_CLASSES - 2; i >= 0; i--)
            if (SLOT_BYTES[i] >= size) c = i;
          r.cls = c[3:0];
          ok    = 1'b0;
          if (opened[c] > 0 && recent[c] < SLABS) begin
            if (claim_slot(c, recent[c], got)) begin
              ok     = 1'b1;
              r.slab = recent[c][1:0];
              r.slot = got[5:0];
            end
          end
          // walk from slab 0, opening slabs on the way
          for (int unsigned s = 0; !ok && s < SLABS; s++) begin
            if (s >= opened[c]) begin
              opened[c] = s + 1;
              recent[c] = s;
            end
            if (claim_slot(c, s, got)) begin
              ok     = 1'b1;
              r.slab = s[1:0];
              r.slot = got[5:0];
            end
          end
          if (ok) live_slots.push_back({r.cls, r.slab, r.slot});
          else r.status = ST_NO_SPACE;
        end
      end else begin
        r.status = ST_NOT_IN_USE;
        r.cls    = fc;
        r.slab   = fs;
        r.slot   = fslot;
        if (fc < NUM_CLASSES && fs < SLABS) begin
          idx = fc * SLABS + fs;
          if (busy_map[idx][fslot]) begin
            busy_map[idx][fslot] = 1'b0;
            if (used_cnt[idx] > 0) used_cnt[idx]--;
            r.status = ST_FREED;
            for (int k = 0; k < live_slots.size(); k++) begin
              if (live_slots[k] == {fc, fs, fslot}) begin
                live_slots.delete(k);
                break;
              end
            end
          end
        end
      end
      pending_replies.push_back(r);
    endfunction

    function automatic void check_result(logic [2:0] status, logic [3:0] cls,
                                         logic [1:0] slab, logic [5:0] slot);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("result with no request pending: status %0d", status);
        errors++;
        return;
      end
      exp = pending_replies.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (cls !== exp.cls) begin
        $error("class_index: expected %0d, actual %0d", exp.cls, cls);
        errors++;
      end
      if (slab !== exp.slab) begin
        $error("slab_index: expected %0d, actual %0d", exp.slab, slab);
        errors++;
      end
      if (slot !== exp.slot) begin
        $error("slot_index: expected %0d, actual %0d", exp.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  slab_book    book;
  int unsigned send_quiet;
  int unsigned recv_quiet;

  size_class_slab_allocator_core #(
    .SLABS_PER_CLASS (SLABS),
    .SLOTS_MAX       (MAX_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Drive one request; entered just after a rising edge, returns at its acceptance
  task automatic send_req(logic kind, logic [19:0] size, logic [3:0] fc, logic [1:0] fs,
                          logic [5:0] fslot);
    int unsigned gap;
    if (send_quiet > 0) begin
      gap = 0;
      send_quiet--;
    end else begin
      if ($urandom_range(0, 29) == 0) send_quiet = $urandom_range(10, 40);
      gap = $urandom_range(0, 12);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {fslot, fs, fc, size};
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_request(kind, size, fc, fs, fslot);
  endtask

  // Size that maps to class c, often at the class edges; now and then too large
  function automatic logic [19:0] size_for_class(int unsigned c);
    int unsigned lo;
    int unsigned pick;
    if ($urandom_range(0, 99) < 6) return 20'($urandom_range(32769, 20'hFFFFF));
    lo   = (c == 0) ? 0 : SLOT_BYTES[c-1] + 1;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 20'(SLOT_BYTES[c]);
    if (pick == 3) return 20'(lo);
    return 20'($urandom_range(lo, SLOT_BYTES[c]));
  endfunction

  // result side: random stalls, checked at each accepted transaction
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    recv_quiet    = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (recv_quiet > 0) begin
        stall = 0;
        recv_quiet--;
      end else begin
        if ($urandom_range(0, 29) == 0) recv_quiet = $urandom_range(10, 40);
        stall = $urandom_range(0, 12);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      book.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[5:4],
                        m_axis_tdata[11:6]);
      @(negedge clk_i);
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_CAP) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned alloc_pct;
    int unsigned c;
    int unsigned k;
    logic [11:0] entry;
    book          = new;
    send_quiet    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_ALLOC;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size edges, bad frees, double free
    send_req(KIND_ALLOC, 20'd0,       4'd0,  2'd0, 6'd0);
    send_req(KIND_ALLOC, 20'd4,       4'd0,  2'd0, 6'd0);
    send_req(KIND_ALLOC, 20'd5,       4'd0,  2'd0, 6'd0);
    send_req(KIND_ALLOC, 20'd32768,   4'd0,  2'd0, 6'd0);
    send_req(KIND_ALLOC, 20'd32769,   4'd15, 2'd3, 6'd63);
    send_req(KIND_ALLOC, 20'hFFFFF,   4'd0,  2'd0, 6'd0);
    send_req(KIND_FREE,  20'd0,       4'd0,  2'd0, 6'd1);
    send_req(KIND_FREE,  20'd0,       4'd0,  2'd0, 6'd1);
    send_req(KIND_FREE,  20'hFFFFF,   4'd12, 2'd0, 6'd0);
    send_req(KIND_FREE,  20'd0,       4'd15, 2'd3, 6'd63);
    send_req(KIND_FREE,  20'd0,       4'd3,  2'd2, 6'd5);
    send_req(KIND_FREE,  20'd0,       4'd11, 2'd0, 6'd40);
    for (int unsigned i = 0; i < NUM_CLASSES; i++)
      send_req(KIND_ALLOC, 20'(SLOT_BYTES[i]), 4'd0, 2'd0, 6'd0);

    // random: fill class 11 first, then mix, drain, and mix again
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      case (n / 200)
        0:       alloc_pct = 85;
        1:       alloc_pct = 55;
        2:       alloc_pct = 25;
        default: alloc_pct = 60;
      endcase
      if ($urandom_range(0, 99) < alloc_pct) begin
        if (n < 200 && $urandom_range(0, 9) < 7) c = NUM_CLASSES - 1;
        else c = $urandom_range(0, NUM_CLASSES - 1);
        send_req(KIND_ALLOC, size_for_class(c), 4'($urandom), 2'($urandom), 6'($urandom));
      end else if (book.live_slots.size() > 0 && $urandom_range(0, 9) < 8) begin
        k     = $urandom_range(0, book.live_slots.size() - 1);
        entry = book.live_slots[k];
        send_req(KIND_FREE, 20'($urandom), entry[11:8], entry[7:6], entry[5:0]);
      end else begin
        send_req(KIND_FREE, 20'($urandom), 4'($urandom), 2'($urandom), 6'($urandom));
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then a short settle
    while (book.pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
